>>> src/waveform_line_plotter_assert.svh
// ----------------------------------------------------------------------------
// Waveform line plotter assertion macros
// Concurrent assertion wrappers shared by the plotter modules.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_LINE_PLOTTER_ASSERT_SVH
`define WAVEFORM_LINE_PLOTTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define WLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define WLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WLP_ASSERT_IMP(lbl, ante, cons, msg)
`define WLP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/wlp_pkg.sv
// ----------------------------------------------------------------------------
// Waveform line plotter package
// Widths, register indexes, microcode types and control/status structs.
// ----------------------------------------------------------------------------
package wlp_pkg;

  localparam int RAW_W       = 16;
  localparam int ROW_W       = 6;
  localparam int COL_OUT_W   = 6;
  localparam int COLOR_W     = 16;
  localparam int YOFF_W      = 8;
  localparam int DIFF_W      = 19;
  localparam int ERR_W       = ROW_W + 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int LINE_DX     = 1;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hF800;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_Y_OFFSET    = 1'b0,
    REG_TRACE_COLOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    UPC_IDLE   = 3'd0,
    UPC_ROW    = 3'd1,
    UPC_SETUP  = 3'd2,
    UPC_LINE   = 3'd3,
    UPC_COMMIT = 3'd4,
    UPC_FIRST  = 3'd5
  } upc_t;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN     = 2'd1,
    COND_FIRST  = 2'd2,
    COND_DONE   = 2'd3
  } cond_t;

  typedef enum logic [2:0] {
    OP_WAIT_IN = 3'd0,
    OP_ROW     = 3'd1,
    OP_SETUP   = 3'd2,
    OP_LINE    = 3'd3,
    OP_COMMIT  = 3'd4,
    OP_FIRST   = 3'd5
  } op_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    upc_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_acc;
    logic first;
    logic done;
  } stat_t;

endpackage

>>> src/wlp_sequencer.sv
// ----------------------------------------------------------------------------
// Waveform line plotter sequencer
// Step counter and control store; issues one datapath operation per step.
// ----------------------------------------------------------------------------
`include "waveform_line_plotter_assert.svh"

module wlp_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  wlp_pkg::stat_t   stat,
  output wlp_pkg::op_t     op
);

  wlp_pkg::upc_t   upc_r;
  wlp_pkg::upc_t   upc_nxt;
  wlp_pkg::ucode_t uword;
  logic            cond_true;

  always_comb begin
    case (upc_r)
      wlp_pkg::UPC_IDLE: begin
        uword = '{wlp_pkg::OP_WAIT_IN, wlp_pkg::COND_IN, 1'b1, wlp_pkg::UPC_ROW};
      end
      wlp_pkg::UPC_ROW: begin
        uword = '{wlp_pkg::OP_ROW, wlp_pkg::COND_ALWAYS, 1'b0, wlp_pkg::UPC_SETUP};
      end
      wlp_pkg::UPC_SETUP: begin
        uword = '{wlp_pkg::OP_SETUP, wlp_pkg::COND_FIRST, 1'b0, wlp_pkg::UPC_FIRST};
      end
      wlp_pkg::UPC_LINE: begin
        uword = '{wlp_pkg::OP_LINE, wlp_pkg::COND_DONE, 1'b1, wlp_pkg::UPC_COMMIT};
      end
      wlp_pkg::UPC_COMMIT: begin
        uword = '{wlp_pkg::OP_COMMIT, wlp_pkg::COND_ALWAYS, 1'b0, wlp_pkg::UPC_IDLE};
      end
      wlp_pkg::UPC_FIRST: begin
        uword = '{wlp_pkg::OP_FIRST, wlp_pkg::COND_DONE, 1'b1, wlp_pkg::UPC_IDLE};
      end
      default: begin
        uword = '{wlp_pkg::OP_WAIT_IN, wlp_pkg::COND_ALWAYS, 1'b0, wlp_pkg::UPC_IDLE};
      end
    endcase
  end

  always_comb begin
    case (uword.cond)
      wlp_pkg::COND_ALWAYS: cond_true = 1'b1;
      wlp_pkg::COND_IN:     cond_true = stat.in_acc;
      wlp_pkg::COND_FIRST:  cond_true = stat.first;
      wlp_pkg::COND_DONE:   cond_true = stat.done;
      default:              cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_nxt = uword.target;
    end else if (uword.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = wlp_pkg::upc_t'(upc_r + 3'd1);
    end
  end

  assign op = uword.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= wlp_pkg::UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  `WLP_ASSERT_NXT(a_accept_to_row, stat.in_acc, upc_r == wlp_pkg::UPC_ROW, "accept did not start row step")
  `WLP_ASSERT_IMP(a_accept_idle, stat.in_acc, upc_r == wlp_pkg::UPC_IDLE, "request taken outside idle step")
  `WLP_ASSERT_NXT(a_setup_branch, (upc_r == wlp_pkg::UPC_SETUP) && !stat.first, upc_r == wlp_pkg::UPC_LINE, "setup did not fall into line step")

endmodule

>>> src/wlp_datapath.sv
// ----------------------------------------------------------------------------
// Waveform line plotter datapath
// Row clamp, line stepper with error accumulators, point state and output stage.
// ----------------------------------------------------------------------------
`include "waveform_line_plotter_assert.svh"

module wlp_datapath #(
  parameter int PLOT_WIDTH  = 51,
  parameter int ROW_ORIGIN  = 40,
  parameter int PLOT_HEIGHT = 41
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wlp_pkg::op_t                         op,
  output wlp_pkg::stat_t                       stat,
  input  logic                                 cfg_we,
  input  logic [wlp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [wlp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wlp_pkg::RAW_W-1:0]            in_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wlp_pkg::COL_OUT_W-1:0]        out_col,
  output logic [wlp_pkg::ROW_W-1:0]            out_row,
  output logic [wlp_pkg::COLOR_W-1:0]          out_color,
  output logic                                 out_last
);

  localparam int COL_W = (PLOT_WIDTH > 2) ? $clog2(PLOT_WIDTH) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(PLOT_WIDTH - 1);
  localparam logic [wlp_pkg::ROW_W-1:0] ROW_MAX = wlp_pkg::ROW_W'(PLOT_HEIGHT - 1);

  logic [wlp_pkg::YOFF_W-1:0]  y_offset_r;
  logic [wlp_pkg::COLOR_W-1:0] trace_color_r;
  logic [wlp_pkg::RAW_W-1:0]   sample_r;
  logic [wlp_pkg::ROW_W-1:0]   tgt_row_r;
  logic [COL_W-1:0]            prev_col_r;
  logic [wlp_pkg::ROW_W-1:0]   prev_row_r;
  logic                        first_r;
  logic [COL_W-1:0]            cx_r;
  logic [wlp_pkg::ROW_W-1:0]   cy_r;
  logic [wlp_pkg::ERR_W-1:0]   ex_r;
  logic [wlp_pkg::ERR_W-1:0]   ey_r;
  logic [wlp_pkg::ROW_W-1:0]   dy_r;
  logic                        up_r;
  logic [wlp_pkg::ROW_W-1:0]   dist_r;
  logic [wlp_pkg::ROW_W-1:0]   t_r;
  logic                        out_valid_r;
  logic [wlp_pkg::COL_OUT_W-1:0] out_col_r;
  logic [wlp_pkg::ROW_W-1:0]   out_row_r;
  logic [wlp_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  logic [wlp_pkg::DIFF_W-1:0]  r_full;
  logic [wlp_pkg::ROW_W-1:0]   row_clamped;
  logic [wlp_pkg::ROW_W-1:0]   dy_calc;
  logic [wlp_pkg::ERR_W-1:0]   ex_inc;
  logic [wlp_pkg::ERR_W-1:0]   ey_inc;
  logic [wlp_pkg::ERR_W-1:0]   dist_ext;
  logic [COL_W-1:0]            col_inc;
  logic                        out_free;
  logic                        line_last;
  logic                        emit;

  assign out_free  = !out_valid_r || out_ready;
  assign line_last = (t_r == dist_r);
  assign emit      = out_free && ((op == wlp_pkg::OP_LINE) || (op == wlp_pkg::OP_FIRST));

  assign in_ready    = (op == wlp_pkg::OP_WAIT_IN);
  assign stat.in_acc = in_valid && (op == wlp_pkg::OP_WAIT_IN);
  assign stat.first  = first_r;
  assign stat.done   = out_free && ((op == wlp_pkg::OP_FIRST) || line_last);

  always_comb begin
    r_full = wlp_pkg::DIFF_W'(y_offset_r)
           - {{(wlp_pkg::DIFF_W - wlp_pkg::RAW_W){sample_r[wlp_pkg::RAW_W-1]}}, sample_r}
           - wlp_pkg::DIFF_W'(ROW_ORIGIN);
    if (r_full[wlp_pkg::DIFF_W-1]) begin
      row_clamped = '0;
    end else if (r_full > wlp_pkg::DIFF_W'(PLOT_HEIGHT - 1)) begin
      row_clamped = ROW_MAX;
    end else begin
      row_clamped = r_full[wlp_pkg::ROW_W-1:0];
    end
  end

  assign dy_calc  = (tgt_row_r >= prev_row_r) ? (tgt_row_r - prev_row_r)
                                               : (prev_row_r - tgt_row_r);
  assign dist_ext = {1'b0, dist_r};
  assign ex_inc   = ex_r + wlp_pkg::ERR_W'(wlp_pkg::LINE_DX);
  assign ey_inc   = ey_r + {1'b0, dy_r};
  assign col_inc  = prev_col_r + COL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_offset_r    <= '0;
      trace_color_r <= wlp_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      case (wlp_pkg::cfg_reg_t'(cfg_addr))
        wlp_pkg::REG_Y_OFFSET:    y_offset_r    <= cfg_wdata[wlp_pkg::YOFF_W-1:0];
        wlp_pkg::REG_TRACE_COLOR: trace_color_r <= cfg_wdata[wlp_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_col_r <= '0;
      prev_row_r <= '0;
      first_r    <= 1'b1;
    end else begin
      if (op == wlp_pkg::OP_COMMIT) begin
        prev_col_r <= (col_inc < COL_LAST) ? col_inc : '0;
        prev_row_r <= tgt_row_r;
      end else if ((op == wlp_pkg::OP_FIRST) && out_free) begin
        prev_col_r <= '0;
        prev_row_r <= tgt_row_r;
        first_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.in_acc) begin
      sample_r <= in_raw;
    end
    if (op == wlp_pkg::OP_ROW) begin
      tgt_row_r <= row_clamped;
    end
    if (op == wlp_pkg::OP_SETUP) begin
      dy_r   <= dy_calc;
      up_r   <= (tgt_row_r > prev_row_r);
      dist_r <= (dy_calc > wlp_pkg::ROW_W'(wlp_pkg::LINE_DX)) ? dy_calc
                                                              : wlp_pkg::ROW_W'(wlp_pkg::LINE_DX);
      ex_r   <= '0;
      ey_r   <= '0;
      cx_r   <= prev_col_r;
      cy_r   <= prev_row_r;
      t_r    <= '0;
    end else if ((op == wlp_pkg::OP_LINE) && out_free) begin
      t_r <= t_r + wlp_pkg::ROW_W'(1);
      if (ex_inc > dist_ext) begin
        ex_r <= ex_inc - dist_ext;
        cx_r <= cx_r + COL_W'(1);
      end else begin
        ex_r <= ex_inc;
      end
      if (ey_inc > dist_ext) begin
        ey_r <= ey_inc - dist_ext;
        cy_r <= up_r ? (cy_r + wlp_pkg::ROW_W'(1)) : (cy_r - wlp_pkg::ROW_W'(1));
      end else begin
        ey_r <= ey_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_color_r <= trace_color_r;
      if (op == wlp_pkg::OP_FIRST) begin
        out_col_r  <= '0;
        out_row_r  <= tgt_row_r;
        out_last_r <= 1'b1;
      end else begin
        out_col_r  <= wlp_pkg::COL_OUT_W'(cx_r);
        out_row_r  <= cy_r;
        out_last_r <= line_last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_color = out_color_r;
  assign out_last  = out_last_r;

  `WLP_ASSERT_IMP(a_line_count, op == wlp_pkg::OP_LINE, t_r <= dist_r, "pixel count ran past line length")
  `WLP_ASSERT_IMP(a_line_row, op == wlp_pkg::OP_LINE, cy_r <= ROW_MAX, "line row left the plot")
  `WLP_ASSERT_NXT(a_first_once, (op == wlp_pkg::OP_FIRST) && out_free, !first_r, "first point flag not cleared")

endmodule

>>> src/waveform_line_plotter.sv
// ----------------------------------------------------------------------------
// Waveform line plotter
// Turns signed samples into trace pixel writes joining consecutive points.
// ----------------------------------------------------------------------------
// Each request on the in_ channel carries one signed sample. The sample is
// mapped to a plot row and a line is drawn from the previous point toward the
// next column, one pixel write request per cycle on the out_ channel while
// out_tready is high. The last pixel of each sample carries out_tlast. The
// first sample after reset produces a single pixel at column 0.
// The block works on one sample at a time under a microcoded step counter.
// in_tready stays low from the accept until the last pixel of the sample has
// entered the output register and, for a line, the commit step has run. A line
// has dist + 1 pixels, where dist is the larger of one and the row span of the
// line (at most PLOT_HEIGHT - 1). The first pixel is registered onto out_tvalid
// after the row, setup and line (or first) steps.
// The output stage is a single register: while the receiver holds out_tready
// low, the pixel stepper waits and no pixel is lost or repeated.
// Reset clears the previous point, restores the default color, and returns
// the sequencer to its idle step; configuration writes take effect at once.
// ----------------------------------------------------------------------------
module waveform_line_plotter #(
  parameter int PLOT_WIDTH  = 51,
  parameter int ROW_ORIGIN  = 40,
  parameter int PLOT_HEIGHT = 41
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wlp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [wlp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // raw_value [15:0]
  input  logic [wlp_pkg::RAW_W-1:0]            in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_col [5:0], pixel_row [11:6], pixel_color [27:12], zero fill [31:28]
  output logic [wlp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  wlp_pkg::op_t   op;
  wlp_pkg::stat_t stat;

  logic [wlp_pkg::COL_OUT_W-1:0] pix_col;
  logic [wlp_pkg::ROW_W-1:0]     pix_row;
  logic [wlp_pkg::COLOR_W-1:0]   pix_color;

  wlp_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  wlp_datapath #(
    .PLOT_WIDTH  (PLOT_WIDTH),
    .ROW_ORIGIN  (ROW_ORIGIN),
    .PLOT_HEIGHT (PLOT_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_raw    (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_col   (pix_col),
    .out_row   (pix_row),
    .out_color (pix_color),
    .out_last  (out_tlast)
  );

  assign out_tdata = {
    {(wlp_pkg::OUT_TDATA_W - wlp_pkg::COLOR_W - wlp_pkg::ROW_W - wlp_pkg::COL_OUT_W){1'b0}},
    pix_color, pix_row, pix_col
  };

endmodule
